>>> hw/rtl/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg: shared types and constants of the biquad filter
// Coefficient format, state word width, rounding points of the digit-serial
// products, register indexes and the sequencer encoding.
// ----------------------------------------------------------------------------
package bqd_pkg;

	// coefficient registers (signed Q3.28)
	localparam int COEF_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_REGS  = 5;

	localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd4;

	// a0 resets to unity gain
	localparam logic signed [COEF_W-1:0] A0_RESET = 32'sh1000_0000;

	// state words: 48 bits, 16 fraction bits below the sample LSB
	localparam int ST_W   = 48;
	localparam int TERM_W = 52;   // a rounded product term
	localparam int SUM_W  = 54;   // sum of two terms and a state word

	localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
	localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

	// digit-serial multiplier lanes
	localparam int LANES     = 3;
	localparam int FB_LANES  = 2;
	localparam int DIG_W     = 4;
	localparam int NUM_DIG   = COEF_W / DIG_W;
	localparam int DIG_CNT_W = 3;
	localparam int PROD_W    = ST_W + DIG_W + 1;
	localparam int ACC_W     = 54;
	localparam int LOW_W     = COEF_W;

	localparam logic [DIG_CNT_W-1:0] LAST_DIG = DIG_CNT_W'(NUM_DIG - 1);

	// rounding: feed-forward to 16 fraction bits from 28, feedback from 44
	localparam int FF_SHIFT  = 12;
	localparam int FB_SHIFT  = 28;
	localparam int OUT_SHIFT = 16;
	localparam int OQ_W      = ST_W + 1 - OUT_SHIFT;

	localparam logic signed [ACC_W-1:0] RND_FF  = ACC_W'(64'd1 << (FF_SHIFT - 1));
	localparam logic signed [ACC_W-1:0] RND_FB  = ACC_W'(64'd1 << (FB_SHIFT - 1));
	localparam logic signed [ST_W:0]    RND_OUT = (ST_W + 1)'(64'd1 << (OUT_SHIFT - 1));

	// sequencer
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL1 = 5'b00010,
		ST_YCAL = 5'b00100,
		ST_MUL2 = 5'b01000,
		ST_UPD  = 5'b10000
	} bqd_state_t;

	// clamp a wide sum into a state word
	function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SUM_W-1:0] v);
		logic ovf;
		ovf = (v[SUM_W-1:ST_W-1] != {(SUM_W-ST_W+1){v[SUM_W-1]}});
		if (!ovf) begin
			return v[ST_W-1:0];
		end else if (v[SUM_W-1]) begin
			return ST_MIN;
		end else begin
			return ST_MAX;
		end
	endfunction

endpackage

>>> hw/rtl/biquad_tdf2_filter.sv
// ----------------------------------------------------------------------------
// biquad_tdf2_filter: per-channel biquad IIR, transposed direct form II
// y = a0*x + s1; s1' = a1*x - b1*y + s2; s2' = a2*x - b2*y, with 48-bit
// saturating state and a rounded, saturated output sample.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-----------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: sample_in, tuser: chan
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: sample_out, tuser: chan_out
//  cfg      | in  | cfg_wen (no back-pressure)    | cfg_index, cfg_data (coef a0..b2)
//
// Back to back an item runs the digit pass for a0/a1/a2*x (ST_MUL1), the step that
// forms y (ST_YCAL), the digit pass for b1/b2*y (ST_MUL2) and the update step
// (ST_UPD), in which the result is registered and the next request is taken.
// The passes run on three shared multiplier lanes, taking a coefficient 4 bits a cycle.
// Reset clears both delay words of every channel and restores the coefficients.
// If the output register is still full the update cycle holds until it drains.

module biquad_tdf2_filter
	import bqd_pkg::*;
#(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// coefficient writes
	input  logic                                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [COEF_W-1:0]                     cfg_data,
	// input samples
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // sample_in
	input  logic                                  s_axis_tuser,  // chan
	// filtered samples
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,  // sample_out
	output logic                                  m_axis_tuser   // chan_out
);

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	bqd_state_t                 st_q;
	logic [DIG_CNT_W-1:0]       dig_q;
	logic signed [COEF_W-1:0]   coef_q [NUM_REGS];
	logic signed [ST_W-1:0]     dly1_q [CHANNELS];
	logic signed [ST_W-1:0]     dly2_q [CHANNELS];

	logic [IDX_W-1:0]           idx_q;
	logic                       chan_q;
	logic signed [ST_W-1:0]     mcand_q;
	logic signed [ST_W-1:0]     y_q;
	logic signed [TERM_W-1:0]   t1_q;
	logic signed [TERM_W-1:0]   t2_q;
	logic signed [ACC_W-1:0]    acc_q [LANES];
	logic [LOW_W-1:0]           low_q [LANES];
	logic [COEF_W-1:0]          csh_q [LANES];

	logic                       m_tvalid_q;
	logic [DATA_W-1:0]          m_tdata_q;
	logic                       m_tuser_q;

	logic                       accept;
	logic                       out_free;
	logic                       lane_step;
	logic [IDX_W-1:0]           idx_in;
	logic signed [ST_W-1:0]     x_ext;
	logic signed [ST_W-1:0]     d1_rd;
	logic signed [ST_W-1:0]     d2_rd;
	logic signed [DIG_W:0]      dig5 [LANES];
	logic signed [PROD_W-1:0]   prod [LANES];
	logic signed [ACC_W-1:0]    lsum [LANES];
	logic signed [TERM_W-1:0]   ff_res [LANES];
	logic signed [TERM_W-1:0]   fb_res [FB_LANES];
	logic signed [ST_W-1:0]     y_sat;
	logic signed [ST_W-1:0]     s1_sat;
	logic signed [ST_W-1:0]     s2_sat;
	logic signed [ST_W:0]       y_rnd;
	logic signed [OQ_W-1:0]     y_int;
	logic [SAMPLE_BITS-1:0]     o_sample;

	// handshake
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign s_axis_tready = (st_q == ST_IDLE) || ((st_q == ST_UPD) && out_free);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign lane_step     = (st_q == ST_MUL1) || (st_q == ST_MUL2);

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	// channel select (chan modulo CHANNELS) and sample sign extension
	assign idx_in = (CHANNELS == 1) ? '0 : IDX_W'(s_axis_tuser);
	assign x_ext  = ST_W'($signed(s_axis_tdata[SAMPLE_BITS-1:0]));
	assign d1_rd  = dly1_q[idx_q];
	assign d2_rd  = dly2_q[idx_q];

	// multiplier lanes: one coefficient digit per cycle, LSB first;
	// the top digit is signed, the rest unsigned
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (dig_q == LAST_DIG) begin
				dig5[l] = {csh_q[l][DIG_W-1], csh_q[l][DIG_W-1:0]};
			end else begin
				dig5[l] = {1'b0, csh_q[l][DIG_W-1:0]};
			end
			prod[l]   = dig5[l] * mcand_q;
			lsum[l]   = acc_q[l] + ACC_W'(prod[l]);
			ff_res[l] = TERM_W'({acc_q[l], low_q[l][LOW_W-1:FF_SHIFT]});
		end
		for (int l = 0; l < FB_LANES; l++) begin
			fb_res[l] = TERM_W'({acc_q[l], low_q[l][LOW_W-1:FB_SHIFT]});
		end
	end

	// y and the new delay words
	assign y_sat  = sat_st(SUM_W'(ff_res[0]) + SUM_W'(d1_rd));
	assign s1_sat = sat_st(SUM_W'(t1_q) - SUM_W'(fb_res[0]) + SUM_W'(d2_rd));
	assign s2_sat = sat_st(SUM_W'(t2_q) - SUM_W'(fb_res[1]));

	// output: round y to an integer, clamp to the sample range
	assign y_rnd = {y_q[ST_W-1], y_q} + RND_OUT;
	assign y_int = y_rnd[ST_W:OUT_SHIFT];

	always_comb begin
		if (y_int[OQ_W-1:SAMPLE_BITS-1] == {(OQ_W-SAMPLE_BITS+1){y_int[OQ_W-1]}}) begin
			o_sample = y_int[SAMPLE_BITS-1:0];
		end else if (y_int[OQ_W-1]) begin
			o_sample = OUT_MIN;
		end else begin
			o_sample = OUT_MAX;
		end
	end

	// sequencer, coefficients, delay state, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			dig_q      <= '0;
			m_tvalid_q <= 1'b0;
			for (int r = 0; r < NUM_REGS; r++) begin
				coef_q[r] <= (r == REG_A0) ? A0_RESET : '0;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				dly1_q[c] <= '0;
				dly2_q[c] <= '0;
			end
		end else begin
			if (cfg_wen && (cfg_index <= REG_B2)) begin
				coef_q[cfg_index] <= cfg_data;
			end

			// drained result; a refill in the update cycle takes precedence
			if (m_tvalid_q && m_axis_tready && (st_q != ST_UPD)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					dig_q <= dig_q + 1'b1;
					if (dig_q == LAST_DIG) begin
						st_q <= ST_YCAL;
					end
				end
				ST_YCAL: begin
					st_q <= ST_MUL2;
				end
				ST_MUL2: begin
					dig_q <= dig_q + 1'b1;
					if (dig_q == LAST_DIG) begin
						st_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (out_free) begin
						dly1_q[idx_q] <= s1_sat;
						dly2_q[idx_q] <= s2_sat;
						m_tvalid_q    <= 1'b1;
						st_q          <= accept ? ST_MUL1 : ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// new request: load x into the lanes with a0, a1, a2
		if (accept) begin
			idx_q    <= idx_in;
			chan_q   <= s_axis_tuser;
			mcand_q  <= x_ext;
			csh_q[0] <= coef_q[REG_A0];
			csh_q[1] <= coef_q[REG_A1];
			csh_q[2] <= coef_q[REG_A2];
			for (int l = 0; l < LANES; l++) begin
				acc_q[l] <= RND_FF;
			end
		end

		// one digit step per lane
		if (lane_step) begin
			for (int l = 0; l < LANES; l++) begin
				acc_q[l] <= lsum[l] >>> DIG_W;
				low_q[l] <= {lsum[l][DIG_W-1:0], low_q[l][LOW_W-1:DIG_W]};
				csh_q[l] <= csh_q[l] >> DIG_W;
			end
		end

		// form y, keep the a1/a2 terms, reload the lanes with y and b1, b2
		if (st_q == ST_YCAL) begin
			y_q      <= y_sat;
			t1_q     <= ff_res[1];
			t2_q     <= ff_res[2];
			mcand_q  <= y_sat;
			csh_q[0] <= coef_q[REG_B1];
			csh_q[1] <= coef_q[REG_B2];
			csh_q[2] <= '0;
			for (int l = 0; l < LANES; l++) begin
				acc_q[l] <= RND_FB;
			end
		end

		// output register
		if ((st_q == ST_UPD) && out_free) begin
			m_tdata_q <= DATA_W'(o_sample);
			m_tuser_q <= chan_q;
		end
	end

	// checks
	a_mul1_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL1 && dig_q == LAST_DIG) |=> (st_q == ST_YCAL))
		else $error("first product pass did not end after the last digit");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (st_q == ST_MUL1 && dig_q == '0))
		else $error("accepted request did not start the digit sequence");

	a_upd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPD && m_tvalid_q && !m_axis_tready) |=> (st_q == ST_UPD && m_tvalid_q))
		else $error("update left while the output register was full");

	a_dig_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE || st_q == ST_YCAL || st_q == ST_UPD) |-> (dig_q == '0))
		else $error("digit counter not at zero outside a product pass");

endmodule
